// ----- rtl/core/lgge_pkg.sv -----
// shared constants, types and control/status bundles for the life grid engine
package lgge_pkg;

    // grid geometry
    localparam int GRID_W = 256;
    localparam int GRID_H = 128;
    localparam int COL_AW = $clog2(GRID_W);
    localparam int ROW_AW = $clog2(GRID_H);
    localparam int CNT_W  = $clog2(GRID_H + 1);

    // command codes carried on s_func
    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_STEP  = 2'd2,
        FN_CLEAR = 2'd3
    } func_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CELL,
        ST_STEP,
        ST_STEP_LAST,
        ST_FINISH
    } state_t;

    // source of a row write
    typedef enum logic [1:0] {
        WR_CELL,
        WR_GEN,
        WR_ZERO
    } wr_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic              load_cmd;
        logic              rd_en;
        logic              wr_en;
        logic              use_pos;
        logic [ROW_AW-1:0] rd_row;
        logic [ROW_AW-1:0] wr_row;
        wr_sel_t           wr_sel;
        logic              shift_en;
        logic              clear_all;
        logic              cap_cell;
        logic              load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        func_t func;
        logic  pos_bad;
    } dp_stat_t;

endpackage

// ----- rtl/core/lgge_dpath.sv -----
// row memory, three-row window, generation logic and result registers
module lgge_dpath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         s_func,
    input  logic [7:0]         s_pos_x,
    input  logic [6:0]         s_pos_y,
    input  logic               s_cell_in,
    input  lgge_pkg::ctrl_cmd_t cmd,
    output lgge_pkg::dp_stat_t  stat,
    output logic               m_cell_out,
    output logic               m_pos_bad
);
    import lgge_pkg::*;

    // one row of the grid per memory word
    logic [GRID_W-1:0] grid_mem [GRID_H];
    logic [GRID_H-1:0] row_vld_reg;

    func_t             func_reg;
    logic [7:0]        pos_x_reg;
    logic [6:0]        pos_y_reg;
    logic              cell_in_reg;
    logic              res_cell_reg;
    logic              m_cell_out_reg;
    logic              m_pos_bad_reg;
    logic [GRID_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic [GRID_W-1:0] prev_reg;
    logic [GRID_W-1:0] cur_reg;

    logic [GRID_W-1:0] row_data;
    logic [GRID_W-1:0] cell_row;
    logic [GRID_W-1:0] gen_row;
    logic [GRID_W-1:0] wr_data;
    logic [ROW_AW-1:0] rd_addr;
    logic [ROW_AW-1:0] wr_addr;
    logic [COL_AW-1:0] col;
    logic              pos_bad;

    // latched word
    always_ff @(posedge aclk) begin
        if (cmd.load_cmd) begin
            func_reg    <= func_t'(s_func);
            pos_x_reg   <= s_pos_x;
            pos_y_reg   <= s_pos_y;
            cell_in_reg <= s_cell_in;
        end
    end

    // position check for cell access
    always_comb begin
        pos_bad = (func_reg inside {FN_WRITE, FN_READ}) &&
                  ((int'(pos_x_reg) >= GRID_W) || (int'(pos_y_reg) >= GRID_H));
    end

    assign stat.func    = func_reg;
    assign stat.pos_bad = pos_bad;

    assign col     = COL_AW'(pos_x_reg);
    assign rd_addr = cmd.use_pos ? ROW_AW'(pos_y_reg) : cmd.rd_row;
    assign wr_addr = cmd.use_pos ? ROW_AW'(pos_y_reg) : cmd.wr_row;

    // rows never written since reset or clear read as dead
    assign row_data = rd_vld_reg ? rd_data_reg : '0;

    // single cell update of the fetched row
    always_comb begin
        cell_row      = row_data;
        cell_row[col] = cell_in_reg;
    end

    // B3/S23 over the window, border columns stay dead
    always_comb begin
        logic [3:0] n;
        gen_row = '0;
        n       = '0;
        for (int c = 1; c < GRID_W - 1; c++) begin
            n = 4'(prev_reg[c-1]) + 4'(prev_reg[c]) + 4'(prev_reg[c+1]) +
                4'(cur_reg[c-1]) + 4'(cur_reg[c+1]) +
                4'(row_data[c-1]) + 4'(row_data[c]) + 4'(row_data[c+1]);
            gen_row[c] = (n == 4'd3) || (cur_reg[c] && (n == 4'd2));
        end
    end

    // write data select
    always_comb begin
        case (cmd.wr_sel)
            WR_CELL: wr_data = cell_row;
            WR_GEN:  wr_data = gen_row;
            WR_ZERO: wr_data = '0;
            default: wr_data = '0;
        endcase
    end

    // row memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // per-row valid bits, cleared at once by reset or clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (cmd.clear_all) begin
                row_vld_reg <= '0;
            end else if (cmd.wr_en) begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    // sliding window of the two rows above the fetched one
    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            prev_reg <= cur_reg;
            cur_reg  <= row_data;
        end
    end

    // result value and output word
    always_ff @(posedge aclk) begin
        if (cmd.load_cmd) begin
            res_cell_reg <= 1'b0;
        end else if (cmd.cap_cell) begin
            res_cell_reg <= (func_reg == FN_READ) ? row_data[col] : 1'b0;
        end
        if (cmd.load_out) begin
            m_cell_out_reg <= res_cell_reg;
            m_pos_bad_reg  <= pos_bad;
        end
    end

    assign m_cell_out = m_cell_out_reg;
    assign m_pos_bad  = m_pos_bad_reg;

endmodule

// ----- rtl/core/lgge_ctrl.sv -----
// command sequencer: decode, cell access, generation sweep, result handoff
module lgge_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  lgge_pkg::dp_stat_t  stat,
    output lgge_pkg::ctrl_cmd_t cmd
);
    import lgge_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             m_valid_reg;
    logic             m_valid_next;

    // state, sweep counter, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.wr_sel = WR_ZERO;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_cmd = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.func)
                    FN_WRITE, FN_READ: begin
                        if (stat.pos_bad) begin
                            state_next = ST_FINISH;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.use_pos = 1'b1;
                            state_next  = ST_CELL;
                        end
                    end
                    FN_STEP: begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_row = '0;
                        cnt_next   = CNT_W'(1);
                        state_next = ST_STEP;
                    end
                    FN_CLEAR: begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_CELL: begin
                cmd.cap_cell = 1'b1;
                if (stat.func == FN_WRITE) begin
                    cmd.wr_en   = 1'b1;
                    cmd.use_pos = 1'b1;
                    cmd.wr_sel  = WR_CELL;
                end
                state_next = ST_FINISH;
            end
            // fetched row is cnt-1; new value of row cnt-2 is written
            ST_STEP: begin
                cmd.shift_en = 1'b1;
                if (cnt_reg != CNT_W'(GRID_H)) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_row = ROW_AW'(cnt_reg);
                end
                if (cnt_reg >= CNT_W'(2)) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_row = ROW_AW'(CNT_W'(cnt_reg - CNT_W'(2)));
                    cmd.wr_sel = (cnt_reg == CNT_W'(2)) ? WR_ZERO : WR_GEN;
                end
                if (cnt_reg == CNT_W'(GRID_H)) begin
                    state_next = ST_STEP_LAST;
                end else begin
                    cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
                end
            end
            // bottom border row
            ST_STEP_LAST: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_row = ROW_AW'(GRID_H - 1);
                cmd.wr_sel = WR_ZERO;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register valid
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/life_grid_generation_engine_unit.sv -----
// top level of the life grid engine: sequencer plus row datapath
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+--------------------------
//  s_      | s_valid s_ready s_func s_pos_x s_pos_y  | command word in
//          | s_cell_in                               |
//  m_      | m_valid m_ready m_cell_out m_pos_bad    | one result word per command
//
//  step: the generation sweep moves one row per cycle through the single read port
//  of the row memory.
//  reset: synchronous aresetn clears all row valid bits, so the grid is dead at once.
//  stalls: a finished result waits in the output register while the next word is
//  taken; the sequencer only holds in its last state if that register is still full.
module life_grid_generation_engine_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_pos_x,
    input  logic [6:0] s_pos_y,
    input  logic       s_cell_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_cell_out,
    output logic       m_pos_bad
);
    import lgge_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer
    lgge_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // grid memory and generation logic
    lgge_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_func     (s_func),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_cell_in  (s_cell_in),
        .cmd        (cmd),
        .stat       (stat),
        .m_cell_out (m_cell_out),
        .m_pos_bad  (m_pos_bad)
    );

endmodule

// ----- rtl/core/lgge_chk.sv -----
// port-level checks for the life grid engine, bound to the top level
module lgge_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_func,
    input logic [7:0] s_pos_x,
    input logic [6:0] s_pos_y,
    input logic       s_cell_in,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_cell_out,
    input logic       m_pos_bad
);

    // no result word right after reset
    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one word in flight: no second accept in the next cycle
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted back to back");

    // an offered word holds until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_func) && $stable(s_pos_x) &&
                                   $stable(s_pos_y) && $stable(s_cell_in)))
        else $error("offered word changed before accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cell_out) && $stable(m_pos_bad)))
        else $error("stalled result changed");

    // a bad position never returns a live cell
    a_bad_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pos_bad) |-> !m_cell_out)
        else $error("bad position with cell value");

endmodule

bind life_grid_generation_engine_unit lgge_chk u_lgge_chk (.*);
